[hw/rtl/dpd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// Shared types and constants for the debug packet deframer.
// Used by the front end, the request queue, the back end and the top level.

package dpd_pkg;

    localparam int BYTE_W  = 8;
    localparam int LEN_W   = 11;
    localparam int LEN_MAX = 2047;

    localparam logic [BYTE_W-1:0] CH_DOLLAR = 8'h24;
    localparam logic [BYTE_W-1:0] CH_HASH   = 8'h23;
    localparam logic [BYTE_W-1:0] CH_PLUS   = 8'h2B;
    localparam logic [BYTE_W-1:0] CH_MINUS  = 8'h2D;

    // Queue between front and back end.
    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;
    localparam int QCNT_W = 3;

    typedef enum logic [1:0] {
        EV_CONTENT    = 2'd0,
        EV_ACCEPT     = 2'd1,
        EV_REJECT     = 2'd2,
        EV_RETRANSMIT = 2'd3
    } evt_t;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_CONTENT = 2'd1,
        PH_CK1     = 2'd2,
        PH_CK2     = 2'd3
    } phase_t;

    // One request from the front end: what the back end must emit.
    typedef struct packed {
        evt_t              kind;
        logic [BYTE_W-1:0] data;
        logic [LEN_W-1:0]  length;
    } cmd_t;

endpackage

`default_nettype wire

[hw/rtl/dpd_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// Front end: takes received bytes, tracks the framing phase, sum and length,
// and turns each byte that causes output into one request. Depends on dpd_pkg.

module dpd_front
    import dpd_pkg::*;
#(
    parameter int MAX_CONTENT = 1024
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic [BYTE_W-1:0] rx_byte,
    input  wire logic              q_full,
    output logic                   push,
    output cmd_t                   push_cmd
);

    localparam int LEN_CAP_I = (MAX_CONTENT < LEN_MAX) ? MAX_CONTENT : LEN_MAX;
    localparam logic [LEN_W-1:0] LEN_CAP = LEN_CAP_I[LEN_W-1:0];

    phase_t            phase_reg, phase_next;
    logic [BYTE_W-1:0] sum_reg, sum_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [3:0]        hd_reg, hd_next;
    logic              hdok_reg, hdok_next;
    logic              hash_reg, hash_next;

    logic              accept;
    logic              is_hex;
    logic [3:0]        hex_val;
    logic              is_hash;
    logic [BYTE_W-1:0] ck;
    logic              pkt_ok;

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;
    assign is_hash  = (rx_byte == CH_HASH);

    always_comb
    begin
        is_hex  = 1'b1;
        hex_val = 4'd0;
        if (rx_byte >= 8'h30 && rx_byte <= 8'h39)
        begin
            hex_val = 4'(rx_byte - 8'h30);
        end
        else if (rx_byte >= 8'h61 && rx_byte <= 8'h66)
        begin
            hex_val = 4'(rx_byte - 8'h57);
        end
        else if (rx_byte >= 8'h41 && rx_byte <= 8'h46)
        begin
            hex_val = 4'(rx_byte - 8'h37);
        end
        else
        begin
            is_hex = 1'b0;
        end
    end

    // Checksum read like strtoul: stop at the first non-hex character.
    always_comb
    begin
        if (!hdok_reg)
        begin
            ck = '0;
        end
        else if (is_hex)
        begin
            ck = {hd_reg, hex_val};
        end
        else
        begin
            ck = {4'd0, hd_reg};
        end
    end

    assign pkt_ok = !(hash_reg || is_hash) && (len_reg != '0) && (ck == sum_reg);

    // Next state.
    always_comb
    begin
        phase_next = phase_reg;
        sum_next   = sum_reg;
        len_next   = len_reg;
        hd_next    = hd_reg;
        hdok_next  = hdok_reg;
        hash_next  = hash_reg;
        if (accept)
        begin
            case (phase_reg)
                PH_IDLE:
                begin
                    if (rx_byte == CH_DOLLAR)
                    begin
                        phase_next = PH_CONTENT;
                        sum_next   = '0;
                        len_next   = '0;
                        hd_next    = '0;
                        hdok_next  = 1'b0;
                        hash_next  = 1'b0;
                    end
                end
                PH_CONTENT:
                begin
                    if (is_hash)
                    begin
                        phase_next = PH_CK1;
                    end
                    else
                    begin
                        sum_next = sum_reg + rx_byte;
                        if (len_reg < LEN_CAP)
                        begin
                            len_next = len_reg + 1'b1;
                        end
                    end
                end
                PH_CK1:
                begin
                    if (is_hash)
                    begin
                        hash_next = 1'b1;
                    end
                    hdok_next  = is_hex;
                    hd_next    = hex_val;
                    phase_next = PH_CK2;
                end
                default:
                begin
                    if (is_hash)
                    begin
                        hash_next = 1'b1;
                    end
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    // Request to the back end.
    always_comb
    begin
        push            = 1'b0;
        push_cmd.kind   = EV_CONTENT;
        push_cmd.data   = '0;
        push_cmd.length = len_reg;
        case (phase_reg)
            PH_IDLE:
            begin
                push          = accept && (rx_byte == CH_MINUS);
                push_cmd.kind = EV_RETRANSMIT;
            end
            PH_CONTENT:
            begin
                push          = accept && !is_hash;
                push_cmd.kind = EV_CONTENT;
                push_cmd.data = rx_byte;
            end
            PH_CK1:
            begin
                push = 1'b0;
            end
            default:
            begin
                push          = accept;
                push_cmd.kind = pkt_ok ? EV_ACCEPT : EV_REJECT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            sum_reg   <= '0;
            len_reg   <= '0;
            hd_reg    <= '0;
            hdok_reg  <= 1'b0;
            hash_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            sum_reg   <= sum_next;
            len_reg   <= len_next;
            hd_reg    <= hd_next;
            hdok_reg  <= hdok_next;
            hash_reg  <= hash_next;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/dpd_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
// Short request queue between the front end and the back end.
// Depends on dpd_pkg for the request type and depth.

module dpd_queue
    import dpd_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire cmd_t push_cmd,
    input  wire logic pop,
    output logic      full,
    output logic      empty,
    output cmd_t      head
);

    cmd_t              entry_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign full  = (count_reg == QCNT_W'(QDEPTH));
    assign empty = (count_reg == '0);
    assign head  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/dpd_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// Back end: expands queued requests into result items and holds them in the
// output register. A rejected packet gives two results. Depends on dpd_pkg.

module dpd_back
    import dpd_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              q_empty,
    input  wire cmd_t              q_head,
    output logic                   pop,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic [1:0]             event_res,
    output logic [BYTE_W-1:0]      content_byte,
    output logic                   tx_valid,
    output logic [BYTE_W-1:0]      tx_byte,
    output logic [LEN_W-1:0]       pkt_len,
    output logic                   last
);

    logic              valid_reg, valid_next;
    logic              nak_pend_reg, nak_pend_next;
    evt_t              ev_reg, ev_next;
    logic [BYTE_W-1:0] cb_reg, cb_next;
    logic              txv_reg, txv_next;
    logic [BYTE_W-1:0] txb_reg, txb_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic              last_reg, last_next;
    logic              load;

    assign load = !valid_reg || !out_stall;
    assign pop  = load && !nak_pend_reg && !q_empty;

    always_comb
    begin
        valid_next    = valid_reg;
        nak_pend_next = nak_pend_reg;
        ev_next       = ev_reg;
        cb_next       = cb_reg;
        txv_next      = txv_reg;
        txb_next      = txb_reg;
        len_next      = len_reg;
        last_next     = last_reg;
        if (load)
        begin
            if (nak_pend_reg)
            begin
                // Second result of a rejected packet; length is still held.
                valid_next    = 1'b1;
                nak_pend_next = 1'b0;
                ev_next       = EV_REJECT;
                txb_next      = CH_MINUS;
                last_next     = 1'b1;
            end
            else if (!q_empty)
            begin
                valid_next = 1'b1;
                ev_next    = q_head.kind;
                cb_next    = '0;
                txv_next   = 1'b0;
                txb_next   = '0;
                len_next   = '0;
                last_next  = 1'b1;
                case (q_head.kind)
                    EV_CONTENT:
                    begin
                        cb_next = q_head.data;
                    end
                    EV_ACCEPT:
                    begin
                        txv_next = 1'b1;
                        txb_next = CH_PLUS;
                        len_next = q_head.length;
                    end
                    EV_REJECT:
                    begin
                        txv_next      = 1'b1;
                        txb_next      = CH_PLUS;
                        len_next      = q_head.length;
                        last_next     = 1'b0;
                        nak_pend_next = 1'b1;
                    end
                    default:
                    begin
                        last_next = 1'b1;
                    end
                endcase
            end
            else
            begin
                valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= 1'b0;
            nak_pend_reg <= 1'b0;
        end
        else
        begin
            valid_reg    <= valid_next;
            nak_pend_reg <= nak_pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ev_reg   <= ev_next;
        cb_reg   <= cb_next;
        txv_reg  <= txv_next;
        txb_reg  <= txb_next;
        len_reg  <= len_next;
        last_reg <= last_next;
    end

    assign out_valid    = valid_reg;
    assign event_res    = ev_reg;
    assign content_byte = cb_reg;
    assign tx_valid     = txv_reg;
    assign tx_byte      = txb_reg;
    assign pkt_len      = len_reg;
    assign last         = last_reg;

endmodule

`default_nettype wire

[hw/rtl/debug_packet_deframer.sv]
`timescale 1ns / 1ps
`default_nettype none
// Debug link packet deframer, top level.
// Input channel: one received byte (rx_byte) per request, with in_valid and
// in_stall. Packets have the form $content#hh. Output channel: one result
// per request (event_res, content_byte, tx_valid, tx_byte, pkt_len,
// last) with out_valid and out_stall. A content byte gives one result, a
// packet end gives one result (accepted) or two (rejected: ack then nak),
// a '-' outside a packet gives a retransmit result, other bytes give none.
// Throughput: one input byte per cycle while in_stall is low. The extra
// result of a rejected packet end is absorbed by the four-entry request queue.
// An accepted byte's request is first written into the queue, and the back
// end then loads its result into the output register.
// When the receiver stalls, results wait in the output register and the
// queue; in_stall rises only once the queue is full.
// Reset puts the deframer outside any packet with empty queue and output.
// Depends on dpd_pkg, dpd_front, dpd_queue and dpd_back.

module debug_packet_deframer
    import dpd_pkg::*;
#(
    parameter int MAX_CONTENT = 1024
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic [BYTE_W-1:0] rx_byte,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic [1:0]             event_res,
    output logic [BYTE_W-1:0]      content_byte,
    output logic                   tx_valid,
    output logic [BYTE_W-1:0]      tx_byte,
    output logic [LEN_W-1:0]       pkt_len,
    output logic                   last
);

    logic q_full;
    logic q_empty;
    logic push;
    logic pop;
    cmd_t push_cmd;
    cmd_t q_head;

    dpd_front #(
        .MAX_CONTENT(MAX_CONTENT)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .rx_byte  (rx_byte),
        .q_full   (q_full),
        .push     (push),
        .push_cmd (push_cmd)
    );

    dpd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .full     (q_full),
        .empty    (q_empty),
        .head     (q_head)
    );

    dpd_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_empty      (q_empty),
        .q_head       (q_head),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .event_res    (event_res),
        .content_byte (content_byte),
        .tx_valid     (tx_valid),
        .tx_byte      (tx_byte),
        .pkt_len      (pkt_len),
        .last         (last)
    );

    // An acknowledgement byte goes out exactly on packet-end results.
    a_tx_on_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (tx_valid == (event_res == EV_ACCEPT || event_res == EV_REJECT)))
        else $error("tx_valid does not match the packet-end event");

    // The ack half of a rejection is followed at once by its nak half.
    a_nak_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && event_res == EV_REJECT && !last)
        |=> (out_valid && event_res == EV_REJECT && tx_byte == CH_MINUS && last))
        else $error("rejected packet without a following nak result");

    // Payload bytes appear only on content results.
    a_content_only: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && event_res != EV_CONTENT) |-> (content_byte == '0))
        else $error("content byte set on a non-content result");

    // Nothing enters the queue while it is full.
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        q_full |-> !push)
        else $error("request pushed into a full queue");

endmodule

`default_nettype wire

[verif/dpd_checker.sv]
`timescale 1ns / 1ps
// Scoreboard for the debug packet deframer: watches both request channels,
// predicts the results of every accepted byte and compares them in order.
// Depends on dpd_pkg for widths, character codes and the event encoding.

module dpd_checker
    import dpd_pkg::*;
#(
    parameter int MAX_CONTENT = 1024
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_stall,
    input  logic [BYTE_W-1:0] rx_byte,
    input  logic              out_valid,
    input  logic              out_stall,
    input  logic [1:0]        event_res,
    input  logic [BYTE_W-1:0] content_byte,
    input  logic              tx_valid,
    input  logic [BYTE_W-1:0] tx_byte,
    input  logic [LEN_W-1:0]  pkt_len,
    input  logic              last,
    output int                fail_count,
    output int                pending
);

    localparam int LEN_CAP = (MAX_CONTENT < LEN_MAX) ? MAX_CONTENT : LEN_MAX;

    typedef struct {
        evt_t              kind;
        logic [BYTE_W-1:0] data;
        logic              ack_valid;
        logic [BYTE_W-1:0] ack_byte;
        logic [LEN_W-1:0]  length;
        logic              final_one;
    } link_result_t;

    link_result_t      expected_results[$];

    phase_t            link_phase;
    logic [BYTE_W-1:0] payload_sum;
    logic [LEN_W-1:0]  payload_len;
    logic [3:0]        ck_high;
    logic              ck_high_ok;
    logic              ck_saw_hash;

    initial
    begin
        fail_count = 0;
        pending    = 0;
    end

    // Returns {is_hex, value}; value is zero for anything that is not a hex digit.
    function automatic logic [4:0] hex_decode(input logic [BYTE_W-1:0] c);
        if (c >= 8'h30 && c <= 8'h39)
            return {1'b1, 4'(c - 8'h30)};
        if (c >= 8'h61 && c <= 8'h66)
            return {1'b1, 4'(c - 8'h61 + 8'd10)};
        if (c >= 8'h41 && c <= 8'h46)
            return {1'b1, 4'(c - 8'h41 + 8'd10)};
        return 5'd0;
    endfunction

    task automatic push_result(input evt_t kind, input logic [BYTE_W-1:0] data,
                               input logic ack_valid, input logic [BYTE_W-1:0] ack_byte,
                               input logic [LEN_W-1:0] length, input logic final_one);
        link_result_t r;
        r.kind      = kind;
        r.data      = data;
        r.ack_valid = ack_valid;
        r.ack_byte  = ack_byte;
        r.length    = length;
        r.final_one = final_one;
        expected_results.push_back(r);
    endtask

    task automatic deframe_byte(input logic [BYTE_W-1:0] c);
        logic [4:0]        digit;
        logic [BYTE_W-1:0] ck;
        case (link_phase)
            PH_IDLE:
            begin
                if (c == CH_MINUS)
                    push_result(EV_RETRANSMIT, '0, 1'b0, '0, '0, 1'b1);
                else if (c == CH_DOLLAR)
                begin
                    link_phase  = PH_CONTENT;
                    payload_sum = '0;
                    payload_len = '0;
                    ck_high     = '0;
                    ck_high_ok  = 1'b0;
                    ck_saw_hash = 1'b0;
                end
            end
            PH_CONTENT:
            begin
                if (c == CH_HASH)
                    link_phase = PH_CK1;
                else
                begin
                    payload_sum = payload_sum + c;
                    if (payload_len < LEN_CAP)
                        payload_len = payload_len + 1'b1;
                    push_result(EV_CONTENT, c, 1'b0, '0, '0, 1'b1);
                end
            end
            PH_CK1:
            begin
                if (c == CH_HASH)
                    ck_saw_hash = 1'b1;
                digit      = hex_decode(c);
                ck_high_ok = digit[4];
                ck_high    = digit[3:0];
                link_phase = PH_CK2;
            end
            default:
            begin
                if (c == CH_HASH)
                    ck_saw_hash = 1'b1;
                digit = hex_decode(c);
                // Digits are read up to the first non-hex byte.
                if (!ck_high_ok)
                    ck = '0;
                else if (digit[4])
                    ck = {ck_high, digit[3:0]};
                else
                    ck = {4'd0, ck_high};
                link_phase = PH_IDLE;
                if (!ck_saw_hash && payload_len != 0 && ck == payload_sum)
                    push_result(EV_ACCEPT, '0, 1'b1, CH_PLUS, payload_len, 1'b1);
                else
                begin
                    push_result(EV_REJECT, '0, 1'b1, CH_PLUS, payload_len, 1'b0);
                    push_result(EV_REJECT, '0, 1'b1, CH_MINUS, payload_len, 1'b1);
                end
            end
        endcase
    endtask

    task automatic check_result();
        link_result_t want;
        if (expected_results.size() == 0)
        begin
            if (fail_count < 10)
                $display("%0t: unexpected result ev=%0d data=%h txv=%0d txb=%h len=%0d last=%0d",
                         $time, event_res, content_byte, tx_valid, tx_byte,
                         pkt_len, last);
            fail_count++;
            return;
        end
        want = expected_results.pop_front();
        if (event_res !== want.kind || content_byte !== want.data ||
            tx_valid !== want.ack_valid || tx_byte !== want.ack_byte ||
            pkt_len !== want.length || last !== want.final_one)
        begin
            if (fail_count < 10)
            begin
                $display("%0t: expected ev=%0d data=%h txv=%0d txb=%h len=%0d last=%0d",
                         $time, want.kind, want.data, want.ack_valid, want.ack_byte,
                         want.length, want.final_one);
                $display("%0t:   actual ev=%0d data=%h txv=%0d txb=%h len=%0d last=%0d",
                         $time, event_res, content_byte, tx_valid, tx_byte,
                         pkt_len, last);
            end
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            link_phase  = PH_IDLE;
            payload_sum = '0;
            payload_len = '0;
            ck_high     = '0;
            ck_high_ok  = 1'b0;
            ck_saw_hash = 1'b0;
            expected_results.delete();
            pending = 0;
        end
        else
        begin
            // A result never leaves in the cycle its byte arrives, so the order is free.
            if (in_valid && !in_stall)
                deframe_byte(rx_byte);
            if (out_valid && !out_stall)
                check_result();
            pending = expected_results.size();
        end
    end

endmodule

[verif/tb.sv]
`timescale 1ns / 1ps
// Top of the deframer testbench: clock, reset, byte stimulus and output stalls.
// Depends on dpd_pkg, debug_packet_deframer and dpd_checker.

module tb;
    import dpd_pkg::*;

    localparam int MAX_CONTENT = 1024;
    localparam int ITEMS_PER_PHASE = 190;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_stall;
    logic [BYTE_W-1:0] rx_byte;
    logic              out_valid;
    logic              out_stall;
    logic [1:0]        event_res;
    logic [BYTE_W-1:0] content_byte;
    logic              tx_valid;
    logic [BYTE_W-1:0] tx_byte;
    logic [LEN_W-1:0]  pkt_len;
    logic              last;
    int                fail_count;
    int                pending;

    logic [BYTE_W-1:0] frame_bytes[$];
    int                sent_items;
    int                idle_pct;
    int                stall_pct;
    int                idle_by_phase[4]  = '{0, 48, 0, 26};
    int                stall_by_phase[4] = '{0, 0, 48, 26};

    debug_packet_deframer #(
        .MAX_CONTENT(MAX_CONTENT)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .rx_byte(rx_byte),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .event_res(event_res),
        .content_byte(content_byte),
        .tx_valid(tx_valid),
        .tx_byte(tx_byte),
        .pkt_len(pkt_len),
        .last(last)
    );

    dpd_checker #(
        .MAX_CONTENT(MAX_CONTENT)
    ) u_chk (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .rx_byte(rx_byte),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .event_res(event_res),
        .content_byte(content_byte),
        .tx_valid(tx_valid),
        .tx_byte(tx_byte),
        .pkt_len(pkt_len),
        .last(last),
        .fail_count(fail_count),
        .pending(pending)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    always @(negedge clk)
    begin
        out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    function automatic logic [BYTE_W-1:0] hex_char(input logic [3:0] v);
        if (v < 10)
            return 8'h30 + v;
        return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + v - 8'd10;
    endfunction

    function automatic logic [BYTE_W-1:0] non_hex_char();
        logic [BYTE_W-1:0] c;
        do
            c = 8'($urandom_range(0, 255));
        while ((c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
               (c >= 8'h41 && c <= 8'h46));
        return c;
    endfunction

    task automatic send_byte(input logic [BYTE_W-1:0] b);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            in_valid <= 1'b0;
            rx_byte  <= 8'($urandom_range(0, 255));
            @(negedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
    endtask

    task automatic send_frame();
        foreach (frame_bytes[i])
            send_byte(frame_bytes[i]);
        frame_bytes.delete();
    endtask

    // Builds one $content#hh packet; most checksums are right, the rest cover
    // wrong digits, a hash in the checksum, one digit only and no digit at all.
    task automatic send_packet(input int len, input bit low_bytes, input bit good_ck);
        logic [BYTE_W-1:0] sum;
        logic [BYTE_W-1:0] c;
        int                mode;
        sum = '0;
        frame_bytes.push_back(CH_DOLLAR);
        repeat (len)
        begin
            if (low_bytes)
                c = 8'($urandom_range(0, 3));
            else if ($urandom_range(0, 19) == 0)
                c = CH_DOLLAR;
            else
                do
                    c = 8'($urandom_range(0, 255));
                while (c == CH_HASH);
            frame_bytes.push_back(c);
            sum = sum + c;
        end
        frame_bytes.push_back(CH_HASH);
        mode = good_ck ? 0 : $urandom_range(0, 99);
        if (mode < 60)
        begin
            frame_bytes.push_back(hex_char(sum[7:4]));
            frame_bytes.push_back(hex_char(sum[3:0]));
        end
        else if (mode < 70)
        begin
            frame_bytes.push_back(hex_char(sum[7:4]));
            frame_bytes.push_back(hex_char(sum[3:0] ^ 4'($urandom_range(1, 15))));
        end
        else if (mode < 78)
        begin
            frame_bytes.push_back(8'($urandom_range(0, 255)));
            frame_bytes.push_back(8'($urandom_range(0, 255)));
        end
        else if (mode < 86)
        begin
            if ($urandom_range(0, 1))
            begin
                frame_bytes.push_back(CH_HASH);
                frame_bytes.push_back(hex_char(sum[3:0]));
            end
            else
            begin
                frame_bytes.push_back(hex_char(sum[7:4]));
                frame_bytes.push_back(CH_HASH);
            end
        end
        else if (mode < 93)
        begin
            frame_bytes.push_back(hex_char(sum[3:0]));
            frame_bytes.push_back(non_hex_char());
        end
        else
        begin
            frame_bytes.push_back(non_hex_char());
            frame_bytes.push_back(hex_char(sum[3:0]));
        end
        sent_items += frame_bytes.size();
        send_frame();
    endtask

    initial
    begin
        int phase_start;
        int pick;
        int len;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        rx_byte    = '0;
        out_stall  = 1'b0;
        idle_pct   = 0;
        stall_pct  = 0;
        sent_items = 0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: retransmit, ignored bytes, empty content, extreme bytes with a
        // dollar inside, one-digit and no-digit checksums, hash in checksum, bad sum.
        frame_bytes = '{CH_MINUS, CH_PLUS, 8'h41,
                        CH_DOLLAR, CH_HASH, 8'h30, 8'h30,
                        CH_DOLLAR, 8'h00, 8'hFF, CH_DOLLAR, CH_HASH, 8'h32, 8'h33,
                        CH_DOLLAR, 8'h05, CH_HASH, 8'h35, 8'h67,
                        CH_DOLLAR, 8'h00, CH_HASH, 8'h7A, 8'h7A,
                        CH_DOLLAR, 8'h80, CH_HASH, CH_HASH, 8'h30,
                        CH_DOLLAR, 8'hAF, CH_HASH, 8'h61, 8'h45};
        send_frame();

        for (int ph = 0; ph < 4; ph++)
        begin
            idle_pct    = idle_by_phase[ph];
            stall_pct   = stall_by_phase[ph];
            phase_start = sent_items;
            // Content past the length limit saturates the counter.
            if (ph == 1)
                send_packet(MAX_CONTENT + 6, 1'b0, 1'b1);
            while (sent_items - phase_start < ITEMS_PER_PHASE)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 75)
                begin
                    len = $urandom_range(0, 9);
                    if (len == 0)
                        send_packet(0, 1'b0, 1'b0);
                    else if (len == 9)
                        send_packet($urandom_range(9, 40), 1'b0, 1'b0);
                    else if ($urandom_range(0, 9) == 0)
                        send_packet($urandom_range(1, 3), 1'b1, 1'b0);
                    else
                        send_packet(len, 1'b0, 1'b0);
                end
                else if (pick < 83)
                begin
                    send_byte(CH_MINUS);
                    sent_items++;
                end
                else if (pick < 90)
                begin
                    repeat ($urandom_range(1, 4))
                    begin
                        send_byte($urandom_range(0, 1) ? CH_PLUS : 8'($urandom_range(0, 255)));
                        sent_items++;
                    end
                end
                else
                begin
                    // Broken framing: an opened packet followed by arbitrary bytes.
                    frame_bytes.push_back(CH_DOLLAR);
                    repeat ($urandom_range(2, 10))
                        frame_bytes.push_back(8'($urandom_range(0, 255)));
                    sent_items += frame_bytes.size();
                    send_frame();
                end
            end
        end

        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
        repeat (10) @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/dpd_pkg.sv
hw/rtl/dpd_front.sv
hw/rtl/dpd_queue.sv
hw/rtl/dpd_back.sv
hw/rtl/debug_packet_deframer.sv
verif/dpd_checker.sv
verif/tb.sv
